### rtl/gkgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gkgm_pkg;

	localparam int COORD_BITS     = 16;
	localparam int MAX_POINTS_DEF = 64;
	localparam int DIMS_DEF       = 2;
	localparam int BW_W           = 16;
	localparam int SCALE_W        = 24;
	localparam int IDX_OUT_W      = 6;
	localparam int DIFF_W         = 22;
	localparam int RAW_W          = 34;
	localparam int Q30_W          = 31;
	localparam int U_W            = 30;
	localparam int PIPE_LAT       = 28;
	localparam int CHAIN_LAT      = 18;

	localparam logic signed [RAW_W-1:0]  DIFF_LIM   = 34'sd1048576;
	localparam logic [Q30_W-1:0]         Q30_ONE    = 31'h4000_0000;
	localparam logic [30:0]              LOG2E_Q30  = 31'd1549082005;
	localparam logic [29:0]              LN2_Q30    = 30'd744261118;
	localparam logic [SCALE_W-1:0]       KMAX       = 24'hFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} gkgm_state_t;

	typedef enum logic [1:0] {
		CFG_BW00,
		CFG_BW01,
		CFG_BW11,
		CFG_SCALE
	} gkgm_cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] coord_0;
		logic signed [COORD_BITS-1:0] coord_1;
		logic                         start_new_set;
	} gkgm_cmd_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] row_index;
		logic [IDX_OUT_W-1:0] column_index;
		logic [SCALE_W-1:0]   kernel_value;
		logic                 last_of_row;
	} gkgm_res_t;

	function automatic logic signed [DIFF_W-1:0] clamp_diff(input logic signed [RAW_W-1:0] v);
		logic signed [DIFF_W-1:0] r;
		if (v > DIFF_LIM)
			r = DIFF_W'(DIFF_LIM);
		else if (v < -DIFF_LIM)
			r = DIFF_W'(-DIFF_LIM);
		else
			r = DIFF_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/gkgm_exp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module gkgm_exp_cell #(
	parameter int K = 1
) (
	input  wire logic                          clk,
	input  wire logic [gkgm_pkg::U_W-1:0]      u_in,
	input  wire logic [gkgm_pkg::Q30_W-1:0]    t_in,
	output logic      [gkgm_pkg::U_W-1:0]      u_out,
	output logic      [gkgm_pkg::Q30_W-1:0]    t_out
);

	// ceiling reciprocal, exact floor quotient for any 30-bit dividend
	localparam longint unsigned RECIP = ((64'd1 << 34) + 64'(K) - 64'd1) / 64'(K);

	logic [gkgm_pkg::U_W-1:0] u_s1;
	logic [29:0]              p_s1;
	logic [60:0]              prod;
	logic [64:0]              quot;

	assign prod = 61'(u_in) * 61'(t_in);
	assign quot = 65'(p_s1) * 65'(RECIP);

	always_ff @(posedge clk) begin
		u_s1  <= u_in;
		p_s1  <= prod[59:30];
		u_out <= u_s1;
		t_out <= gkgm_pkg::Q30_ONE - 31'(quot[63:34]);
	end

endmodule
`default_nettype wire

### rtl/gkgm_kernel_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module gkgm_kernel_pipe #(
	parameter int IDX_W = 6
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_vld,
	input  wire logic [IDX_W-1:0]                       in_col,
	input  wire logic                                   in_last,
	input  wire logic signed [gkgm_pkg::COORD_BITS-1:0] cur_c0,
	input  wire logic signed [gkgm_pkg::COORD_BITS-1:0] cur_c1,
	input  wire logic signed [gkgm_pkg::COORD_BITS-1:0] st_c0,
	input  wire logic signed [gkgm_pkg::COORD_BITS-1:0] st_c1,
	input  wire logic signed [gkgm_pkg::BW_W-1:0]       s00,
	input  wire logic signed [gkgm_pkg::BW_W-1:0]       s01,
	input  wire logic signed [gkgm_pkg::BW_W-1:0]       s11,
	input  wire logic [gkgm_pkg::SCALE_W-1:0]           scale,
	output logic                                        out_vld,
	output logic [IDX_W-1:0]                            out_col,
	output logic                                        out_last,
	output logic [gkgm_pkg::SCALE_W-1:0]                out_kernel
);

	localparam int LAT = gkgm_pkg::PIPE_LAT;
	localparam int CL  = gkgm_pkg::CHAIN_LAT;

	logic             vld_d  [LAT];
	logic [IDX_W-1:0] col_d  [LAT];
	logic             last_d [LAT];

	logic signed [gkgm_pkg::DIFF_W-1:0] d0_s1, d1_s1;
	logic signed [43:0] p00_s2, p01_s2, p11_s2;
	logic signed [59:0] a_s3, b_s3, c_s3;
	logic signed [61:0] q_s4;
	logic [22:0]        x_s5;
	logic               grow_s5, grow_s6;
	logic [23:0]        y_s6;
	logic [16:0]        g_s7;
	logic signed [8:0]  e_s7, e_s8, e_sp;
	logic [gkgm_pkg::U_W-1:0] u_s8;
	logic signed [8:0]  e_d [CL];
	logic [54:0]        prod_sp;

	logic [61:0] mag;
	logic [62:0] mag_rnd;
	logic [54:0] y_full;
	logic [7:0]  n_w;
	logic [15:0] f_w;
	logic [46:0] u_full;
	logic [7:0]  shift;
	logic [63:0] rnd;
	logic [63:0] r_w;
	logic [gkgm_pkg::SCALE_W-1:0] kv;

	logic [gkgm_pkg::U_W-1:0]   u_c [10];
	logic [gkgm_pkg::Q30_W-1:0] t_c [10];

	assign mag     = q_s4[61] ? 62'(-q_s4) : 62'(q_s4);
	assign mag_rnd = (63'(mag) + 63'd4096) >> 13;
	assign y_full  = 55'(x_s5) * 55'(gkgm_pkg::LOG2E_Q30) + 55'(64'd1 << 29);
	assign n_w     = y_s6[23:16];
	assign f_w     = y_s6[15:0];
	assign u_full  = 47'(g_s7) * 47'(gkgm_pkg::LN2_Q30);

	always_ff @(posedge clk) begin
		d0_s1  <= gkgm_pkg::clamp_diff(34'(cur_c0) - 34'(st_c0));
		d1_s1  <= gkgm_pkg::clamp_diff(34'(cur_c1) - 34'(st_c1));
		p00_s2 <= 44'(d0_s1) * 44'(d0_s1);
		p01_s2 <= 44'(d0_s1) * 44'(d1_s1);
		p11_s2 <= 44'(d1_s1) * 44'(d1_s1);
		a_s3   <= 60'(p00_s2) * 60'(s00);
		b_s3   <= 60'(p01_s2) * 60'(s01);
		c_s3   <= 60'(p11_s2) * 60'(s11);
		q_s4   <= 62'(a_s3) + (62'(b_s3) <<< 1) + 62'(c_s3);
		grow_s5 <= q_s4[61];
		// saturate |x| at 64.0
		x_s5   <= (mag_rnd > 63'(23'h40_0000)) ? 23'h40_0000 : 23'(mag_rnd);
		grow_s6 <= grow_s5;
		y_s6   <= y_full[53:30];
		if (!grow_s6) begin
			e_s7 <= -9'(n_w);
			g_s7 <= 17'(f_w);
		end else if (f_w != 16'd0) begin
			e_s7 <= 9'(n_w) + 9'sd1;
			g_s7 <= 17'h1_0000 - 17'(f_w);
		end else begin
			e_s7 <= 9'(n_w);
			g_s7 <= 17'd0;
		end
		e_s8   <= e_s7;
		u_s8   <= u_full[45:16];
		e_d[0] <= e_s8;
		for (int k = 1; k < CL; k++)
			e_d[k] <= e_d[k-1];
		e_sp    <= e_d[CL-1];
		prod_sp <= 55'(scale) * 55'(t_c[9]);
		out_kernel <= kv;
	end

	assign u_c[0] = u_s8;
	assign t_c[0] = gkgm_pkg::Q30_ONE;

	for (genvar c = 0; c < 9; c++) begin : g_chain
		gkgm_exp_cell #(.K(9 - c)) u_cell (
			.clk   (clk),
			.u_in  (u_c[c]),
			.t_in  (t_c[c]),
			.u_out (u_c[c+1]),
			.t_out (t_c[c+1])
		);
	end

	always_comb begin
		shift = 8'(9'sd30 - e_sp);
		rnd   = 64'd1 << (shift - 8'd1);
		r_w   = (64'(prod_sp) + rnd) >> shift;
		if (e_sp > 9'sd9)
			kv = (scale != '0) ? gkgm_pkg::KMAX : '0;
		else if (shift > 8'd62)
			kv = '0;
		else if (r_w > 64'(gkgm_pkg::KMAX))
			kv = gkgm_pkg::KMAX;
		else
			kv = r_w[gkgm_pkg::SCALE_W-1:0];
	end

	// tags ride alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++)
				vld_d[k] <= 1'b0;
		end else begin
			vld_d[0] <= in_vld;
			for (int k = 1; k < LAT; k++)
				vld_d[k] <= vld_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		col_d[0]  <= in_col;
		last_d[0] <= in_last;
		for (int k = 1; k < LAT; k++) begin
			col_d[k]  <= col_d[k-1];
			last_d[k] <= last_d[k-1];
		end
	end

	assign out_vld  = vld_d[LAT-1];
	assign out_col  = col_d[LAT-1];
	assign out_last = last_d[LAT-1];

endmodule
`default_nettype wire

### rtl/gaussian_kernel_gram_matrix.sv
// The diagonal entry appears in the cycle after start is taken; the entries (i, j)
// follow from the store and kernel pipeline, one per cycle in column order.
// Point i > 0 keeps busy high until its last entry leaves the 28-stage kernel
// pipeline (nine-cell exp chain), so no new point is taken while a row is in
// flight; the store is read once per column. Point 0 leaves busy low.
// Reset clears the point count and sequencer and sets the config registers to
// their defaults; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_kernel_gram_matrix #(
	parameter int MAX_POINTS = gkgm_pkg::MAX_POINTS_DEF,
	parameter int DIMS       = gkgm_pkg::DIMS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire gkgm_pkg::gkgm_cmd_t           cmd,
	output logic                               result_valid,
	output gkgm_pkg::gkgm_res_t                result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [gkgm_pkg::SCALE_W-1:0]  cfg_data
);

	localparam int CB    = gkgm_pkg::COORD_BITS;
	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int MEM_W = DIMS * CB;

	gkgm_pkg::gkgm_state_t state_q, state_d;

	logic signed [gkgm_pkg::BW_W-1:0] s00_q, s01_q, s11_q;
	logic [gkgm_pkg::SCALE_W-1:0]     scale_q;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] row_q, j_q, i_new;
	logic signed [CB-1:0] cur_c0_q, cur_c1_q;
	logic [MEM_W-1:0] mem [MAX_POINTS];
	logic [MEM_W-1:0] rd_q;
	logic             rd_vld_q, rd_last_q;
	logic [IDX_W-1:0] rd_col_q;
	logic             accept, issue_last;
	logic signed [CB-1:0] st_c0, st_c1;

	logic                         p_vld, p_last;
	logic [IDX_W-1:0]             p_col;
	logic [gkgm_pkg::SCALE_W-1:0] p_kernel;

	assign busy       = (state_q != gkgm_pkg::ST_IDLE);
	assign accept     = start & ~busy;
	assign cfg_ready  = 1'b1;
	assign i_new      = (cmd.start_new_set || count_q >= CNT_W'(MAX_POINTS))
	                    ? '0 : count_q[IDX_W-1:0];
	assign issue_last = (j_q == row_q - IDX_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s00_q   <= 16'sd4096;
			s01_q   <= '0;
			s11_q   <= 16'sd4096;
			scale_q <= 24'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (gkgm_pkg::gkgm_cfg_idx_t'(cfg_index))
				gkgm_pkg::CFG_BW00:  s00_q   <= cfg_data[gkgm_pkg::BW_W-1:0];
				gkgm_pkg::CFG_BW01:  s01_q   <= cfg_data[gkgm_pkg::BW_W-1:0];
				gkgm_pkg::CFG_BW11:  s11_q   <= cfg_data[gkgm_pkg::BW_W-1:0];
				gkgm_pkg::CFG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gkgm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gkgm_pkg::ST_IDLE:  if (accept && i_new != '0) state_d = gkgm_pkg::ST_ISSUE;
			gkgm_pkg::ST_ISSUE: if (issue_last) state_d = gkgm_pkg::ST_DRAIN;
			gkgm_pkg::ST_DRAIN: if (p_vld && p_last) state_d = gkgm_pkg::ST_IDLE;
			default:            state_d = gkgm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rd_vld_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (accept)
				count_q <= CNT_W'(i_new) + CNT_W'(1);
			rd_vld_q     <= (state_q == gkgm_pkg::ST_ISSUE);
			result_valid <= accept | p_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[i_new] <= MEM_W'({cmd.coord_1, cmd.coord_0});
			row_q      <= i_new;
			j_q        <= '0;
			cur_c0_q   <= cmd.coord_0;
			cur_c1_q   <= (DIMS > 1) ? cmd.coord_1 : '0;
		end else if (state_q == gkgm_pkg::ST_ISSUE) begin
			j_q <= j_q + IDX_W'(1);
		end
		rd_q      <= mem[j_q];
		rd_col_q  <= j_q;
		rd_last_q <= issue_last;
	end

	assign st_c0 = rd_q[CB-1:0];
	assign st_c1 = (DIMS > 1) ? rd_q[MEM_W-1 -: CB] : '0;

	gkgm_kernel_pipe #(.IDX_W(IDX_W)) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (rd_vld_q),
		.in_col     (rd_col_q),
		.in_last    (rd_last_q),
		.cur_c0     (cur_c0_q),
		.cur_c1     (cur_c1_q),
		.st_c0      (st_c0),
		.st_c1      (st_c1),
		.s00        (s00_q),
		.s01        (s01_q),
		.s11        (s11_q),
		.scale      (scale_q),
		.out_vld    (p_vld),
		.out_col    (p_col),
		.out_last   (p_last),
		.out_kernel (p_kernel)
	);

	// diagonal goes out right after the request, pipeline entries later
	always_ff @(posedge clk) begin
		if (accept) begin
			result.row_index    <= gkgm_pkg::IDX_OUT_W'(i_new);
			result.column_index <= gkgm_pkg::IDX_OUT_W'(i_new);
			result.kernel_value <= scale_q;
			result.last_of_row  <= (i_new == '0);
		end else begin
			result.row_index    <= gkgm_pkg::IDX_OUT_W'(row_q);
			result.column_index <= gkgm_pkg::IDX_OUT_W'(p_col);
			result.kernel_value <= p_kernel;
			result.last_of_row  <= p_last;
		end
	end

endmodule
`default_nettype wire

### rtl/gkgm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gkgm_props (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                result_valid,
	input wire gkgm_pkg::gkgm_res_t result
);

	a_diag_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> result_valid && result.row_index == result.column_index)
		else $error("diagonal entry missing after request");

	a_busy_mid_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_row |-> busy)
		else $error("row still open but block idle");

	a_col_below_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.column_index != result.row_index
		|-> result.column_index < result.row_index)
		else $error("off-diagonal column not below row");

endmodule

bind gaussian_kernel_gram_matrix gkgm_props u_gkgm_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
`default_nettype wire

### tb/gkgm_checker.sv
`timescale 1ns / 1ps
module gkgm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  gkgm_pkg::gkgm_cmd_t           cmd,
	input  logic                          result_valid,
	input  gkgm_pkg::gkgm_res_t           result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [23:0]                   cfg_data,
	output int                            errors,
	output int                            pending
);

	localparam int NPTS = gkgm_pkg::MAX_POINTS_DEF;

	logic signed [15:0]  bw00, bw01, bw11;
	logic [23:0]         scale;
	longint              pt_c0 [NPTS];
	longint              pt_c1 [NPTS];
	int                  npts;
	gkgm_pkg::gkgm_res_t entries_due[$];

	// 2^-g in Q30 for a Q16 fraction g
	function automatic longint unsigned exp2_mant(longint unsigned g);
		longint unsigned u, t;
		u = (g * 64'd744261118) >> 16;
		t = 64'd1 << 30;
		for (int k = 9; k >= 1; k--)
			t = (64'd1 << 30) - ((u * t) >> 30) / k;
		return t;
	endfunction

	function automatic logic [23:0] gauss_entry(longint q, logic [23:0] s);
		longint unsigned mag, x16, y16, n, f, mant, prod, r;
		longint e, sh;
		mag = (q < 0) ? -q : q;
		x16 = (mag + 4096) >> 13;
		if (x16 > (64'd64 << 16)) x16 = 64'd64 << 16;
		y16 = (x16 * 64'd1549082005 + (64'd1 << 29)) >> 30;
		n = y16 >> 16;
		f = y16 & 64'hFFFF;
		if (q < 0) begin
			if (f != 0) begin
				e = n + 1;
				mant = exp2_mant(65536 - f);
			end else begin
				e = n;
				mant = exp2_mant(0);
			end
		end else begin
			e = -longint'(n);
			mant = exp2_mant(f);
		end
		if (e > 9) return (s != 0) ? gkgm_pkg::KMAX : 24'd0;
		sh = 30 - e;
		if (sh > 62) return 24'd0;
		prod = s * mant;
		r = (prod + (64'd1 << (sh - 1))) >> sh;
		return (r > 64'hFFFFFF) ? gkgm_pkg::KMAX : r[23:0];
	endfunction

	function automatic longint clip_diff(longint d);
		if (d > (64'sd1 << 20)) return 64'sd1 << 20;
		if (d < -(64'sd1 << 20)) return -(64'sd1 << 20);
		return d;
	endfunction

	task automatic predict_row(gkgm_pkg::gkgm_cmd_t c);
		longint              c0, c1, d0, d1, q;
		int                  row;
		gkgm_pkg::gkgm_res_t r;
		c0 = c.coord_0;
		c1 = c.coord_1;
		if (c.start_new_set || npts >= NPTS) npts = 0;
		row = npts;
		pt_c0[row] = c0;
		pt_c1[row] = c1;
		npts = row + 1;
		r.row_index = row[5:0];
		r.column_index = row[5:0];
		r.kernel_value = scale;
		r.last_of_row = (row == 0);
		entries_due.push_back(r);
		for (int j = 0; j < row; j++) begin
			d0 = clip_diff(c0 - pt_c0[j]);
			d1 = clip_diff(c1 - pt_c1[j]);
			q = d0 * d0 * longint'(bw00) + 2 * d0 * d1 * longint'(bw01)
				+ d1 * d1 * longint'(bw11);
			r.column_index = j[5:0];
			r.kernel_value = gauss_entry(q, scale);
			r.last_of_row = (j + 1 == row);
			entries_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gkgm_pkg::gkgm_res_t want;
		if (!arst_n) begin
			bw00 <= 16'sd4096;
			bw01 <= 16'sd0;
			bw11 <= 16'sd4096;
			scale <= 24'd65536;
			npts = 0;
			errors = 0;
			entries_due.delete();
			pending = 0;
		end else begin
			if (start && !busy) predict_row(cmd);
			if (result_valid) begin
				if (entries_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %p", $time, result);
				end else begin
					want = entries_due.pop_front();
					if (result.row_index !== want.row_index ||
					    result.column_index !== want.column_index ||
					    result.kernel_value !== want.kernel_value ||
					    result.last_of_row !== want.last_of_row) begin
						errors++;
						$display("%0t: expected %p, actual %p", $time, want, result);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (gkgm_pkg::gkgm_cfg_idx_t'(cfg_index))
					gkgm_pkg::CFG_BW00:  bw00 <= cfg_data[15:0];
					gkgm_pkg::CFG_BW01:  bw01 <= cfg_data[15:0];
					gkgm_pkg::CFG_BW11:  bw11 <= cfg_data[15:0];
					gkgm_pkg::CFG_SCALE: scale <= cfg_data;
					default: ;
				endcase
			end
			pending = entries_due.size();
		end
	end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	gkgm_pkg::gkgm_cmd_t cmd = '0;
	logic                result_valid;
	gkgm_pkg::gkgm_res_t result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [23:0]         cfg_data = '0;
	int                  errors, pending;
	int                  cycles = 0;
	logic                no_gaps = 1'b0;

	gaussian_kernel_gram_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gkgm_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("gaussian_kernel_gram_matrix: mismatch");
			$finish;
		end
	end

	// start is left high from the last request; drop it only for a gap
	task automatic send_point(logic signed [15:0] c0, logic signed [15:0] c1, logic fresh);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		cmd <= '{coord_0: c0, coord_1: c1, start_new_set: fresh};
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(gkgm_pkg::gkgm_cfg_idx_t idx, logic [23:0] val);
		@(negedge clk);
		start <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_setting(logic [15:0] s00, logic [15:0] s01, logic [15:0] s11,
		logic [23:0] sc);
		settle();
		write_reg(gkgm_pkg::CFG_BW00, {8'd0, s00});
		write_reg(gkgm_pkg::CFG_BW01, {8'd0, s01});
		write_reg(gkgm_pkg::CFG_BW11, {8'd0, s11});
		write_reg(gkgm_pkg::CFG_SCALE, sc);
	endtask

	// well-formed sets of near points with random content, some wild points
	task automatic random_points(int count, int max_set);
		logic signed [15:0] b0, b1, c0, c1;
		int left;
		left = 0;
		for (int k = 0; k < count; k++) begin
			if (k % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if (left == 0) begin
				left = $urandom_range(1, max_set);
				b0 = 16'($urandom);
				b1 = 16'($urandom);
			end
			if ($urandom_range(0, 4) == 0) begin
				c0 = 16'($urandom);
				c1 = 16'($urandom);
			end else begin
				c0 = b0 + $signed(11'($urandom));
				c1 = b1 + $signed(11'($urandom));
			end
			send_point(c0, c1, left == 1 ? 1'b0 : ($urandom_range(0, 9) == 0));
			left--;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset bandwidth: identical points, unit steps, extreme coordinates
		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd256, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd256, 1'b0);
		send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_point(-16'sh8000, -16'sh8000, 1'b0);
		send_point(16'sd1, -16'sd1, 1'b1);
		send_point(16'sh7FFF, -16'sh8000, 1'b0);

		// negative definite matrix, growth past one
		load_setting(16'h8000, 16'h7FFF, 16'h8000, 24'd1);
		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd3, 16'sd0, 1'b0);
		send_point(16'sd1000, -16'sd1000, 1'b0);
		send_point(-16'sh8000, 16'sh7FFF, 1'b0);

		load_setting(16'h0100, 16'h0040, 16'h0200, 24'hFFFFFF);
		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd512, 16'sd256, 1'b0);
		send_point(-16'sd512, 16'sd300, 1'b0);
		random_points(20, 6);
		// overflow the point store to restart the set
		send_point(16'sd0, 16'sd0, 1'b1);
		for (int k = 0; k < 66; k++) send_point(16'($urandom), 16'($urandom), 1'b0);

		load_setting(16'h7FFF, 16'h8000, 16'h7FFF, 24'd0);
		random_points(15, 8);

		load_setting(16'h1000, 16'hF800, 16'h0800, 24'd65536);
		random_points(25, 8);

		load_setting(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
		random_points(15, 6);

		load_setting(16'h0040, 16'h0000, 16'h0040, 24'hFFFFFF);
		random_points(15, 10);

		settle();
		if (errors == 0 && pending == 0) begin
			$display("gaussian_kernel_gram_matrix: match");
		end else begin
			$display("gaussian_kernel_gram_matrix: mismatch");
		end
		$finish;
	end
endmodule
